>>> src/tpr_pkg.sv
// shared constants for the two-way pair result cache
package tpr_pkg;

    localparam int VALUE_W = 31;

    // power of two, so the set index is the low bits of the folded hash
    localparam int SET_COUNT = 128;

    // set index hash
    localparam int HASH_W      = 32;
    localparam int SHIFT_SRC_Y = 7;
    localparam int SHIFT_DST_X = 13;
    localparam int SHIFT_DST_Y = 17;
    localparam int SHIFT_FOLD  = 16;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

>>> src/tpr_ram.sv
// generic simple dual-port ram with registered read
module tpr_ram #(
    parameter int WIDTH = 71,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tpr_hash.sv
// xor-shift hash of the four key coordinates into a set index
module tpr_hash #(
    parameter int COORD_BITS = 10,
    parameter int SET_BITS   = 7
) (
    input  logic [COORD_BITS-1:0] src_x,
    input  logic [COORD_BITS-1:0] src_y,
    input  logic [COORD_BITS-1:0] dst_x,
    input  logic [COORD_BITS-1:0] dst_y,
    output logic [SET_BITS-1:0]   set_index
);

    logic [tpr_pkg::HASH_W-1:0] mix;
    logic [tpr_pkg::HASH_W-1:0] folded;

    always_comb
    begin
        mix = tpr_pkg::HASH_W'(src_x)
            ^ (tpr_pkg::HASH_W'(src_y) << tpr_pkg::SHIFT_SRC_Y)
            ^ (tpr_pkg::HASH_W'(dst_x) << tpr_pkg::SHIFT_DST_X)
            ^ (tpr_pkg::HASH_W'(dst_y) << tpr_pkg::SHIFT_DST_Y);
        folded = mix ^ (mix >> tpr_pkg::SHIFT_FOLD);
    end

    // set count is a power of two, so the modulo keeps the low bits
    assign set_index = folded[SET_BITS-1:0];

endmodule

>>> src/two_way_pair_result_cache.sv
// top level: two-way set-associative result cache keyed by a coordinate pair
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  req     | in        | req_valid, req_stall | opcode, src_x, src_y, dst_x, dst_y, value
//  res     | out       | res_valid, res_stall | hit, read_value
//
// one request per cycle while req_stall is low; each result is registered after its request is accepted
// (hash and way ram read at the accepting edge, then compare and update into the result register)
// way valid bits and round-robin bits are flip-flops, so reset and clear take effect at once
// a back-to-back write to the same set is forwarded around the way ram read
// when res_stall holds a result, the staged request waits and req_stall rises behind it
module two_way_pair_result_cache #(
    parameter int COORD_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [1:0]                  opcode,
    input  logic [COORD_BITS-1:0]       src_x,
    input  logic [COORD_BITS-1:0]       src_y,
    input  logic [COORD_BITS-1:0]       dst_x,
    input  logic [COORD_BITS-1:0]       dst_y,
    input  logic [tpr_pkg::VALUE_W-1:0] value,
    output logic                        res_valid,
    input  logic                        res_stall,
    output logic                        hit,
    output logic [tpr_pkg::VALUE_W-1:0] read_value
);

    localparam int SET_BITS = $clog2(tpr_pkg::SET_COUNT);
    localparam int WAYS     = 2 * tpr_pkg::SET_COUNT;
    localparam int KEY_W    = 4 * COORD_BITS;
    localparam int ENTRY_W  = KEY_W + tpr_pkg::VALUE_W;

    logic                        out_free;
    logic                        advance;
    logic                        accept;
    logic [SET_BITS-1:0]         req_set;

    logic                        s1_valid_reg;
    logic [1:0]                  s1_op_reg;
    logic [SET_BITS-1:0]         s1_set_reg;
    logic [KEY_W-1:0]            s1_key_reg;
    logic [tpr_pkg::VALUE_W-1:0] s1_value_reg;

    logic                        bp_valid_reg;
    logic                        bp_way_reg;
    logic [SET_BITS-1:0]         bp_set_reg;
    logic [ENTRY_W-1:0]          bp_entry_reg;

    logic [WAYS-1:0]                  valid_reg;
    logic [WAYS-1:0]                  valid_next;
    logic [tpr_pkg::SET_COUNT-1:0]    rb_reg;
    logic [tpr_pkg::SET_COUNT-1:0]    rb_next;

    logic                        res_valid_reg;
    logic                        hit_reg;
    logic                        hit_next;
    logic [tpr_pkg::VALUE_W-1:0] read_value_reg;
    logic [tpr_pkg::VALUE_W-1:0] read_value_next;

    logic [ENTRY_W-1:0]          rd0;
    logic [ENTRY_W-1:0]          rd1;
    logic [ENTRY_W-1:0]          entry0;
    logic [ENTRY_W-1:0]          entry1;
    logic [KEY_W-1:0]            key0;
    logic [KEY_W-1:0]            key1;
    logic [tpr_pkg::VALUE_W-1:0] val0;
    logic [tpr_pkg::VALUE_W-1:0] val1;
    logic                        v0;
    logic                        v1;
    logic                        m0;
    logic                        m1;

    logic                        s1_write;
    logic                        s1_clear;
    logic                        s1_flip;
    logic                        wr_way;
    logic [1:0]                  wr_en;
    logic [ENTRY_W-1:0]          wr_entry;

    assign out_free  = !res_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    tpr_hash #(
        .COORD_BITS (COORD_BITS),
        .SET_BITS   (SET_BITS)
    ) u_hash (
        .src_x     (src_x),
        .src_y     (src_y),
        .dst_x     (dst_x),
        .dst_y     (dst_y),
        .set_index (req_set)
    );

    tpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (tpr_pkg::SET_COUNT)
    ) u_way0_ram (
        .clk   (clk),
        .we    (wr_en[0]),
        .waddr (s1_set_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (req_set),
        .rdata (rd0)
    );

    tpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (tpr_pkg::SET_COUNT)
    ) u_way1_ram (
        .clk   (clk),
        .we    (wr_en[1]),
        .waddr (s1_set_reg),
        .wdata (wr_entry),
        .re    (accept),
        .raddr (req_set),
        .rdata (rd1)
    );

    // the ram read missed a write made at the same edge: take the forwarded entry
    always_comb
    begin
        entry0 = rd0;
        entry1 = rd1;
        if (bp_valid_reg && (bp_set_reg == s1_set_reg))
        begin
            if (bp_way_reg)
            begin
                entry1 = bp_entry_reg;
            end
            else
            begin
                entry0 = bp_entry_reg;
            end
        end
    end

    assign key0 = entry0[tpr_pkg::VALUE_W +: KEY_W];
    assign key1 = entry1[tpr_pkg::VALUE_W +: KEY_W];
    assign val0 = entry0[tpr_pkg::VALUE_W-1:0];
    assign val1 = entry1[tpr_pkg::VALUE_W-1:0];
    assign v0   = valid_reg[{s1_set_reg, 1'b0}];
    assign v1   = valid_reg[{s1_set_reg, 1'b1}];
    assign m0   = v0 && (key0 == s1_key_reg);
    assign m1   = !m0 && v1 && (key1 == s1_key_reg);

    assign wr_entry = {s1_key_reg, s1_value_reg};

    always_comb
    begin
        hit_next        = 1'b0;
        read_value_next = '0;
        s1_write        = 1'b0;
        s1_clear        = 1'b0;
        s1_flip         = 1'b0;
        wr_way          = 1'b0;
        case (s1_op_reg)
            tpr_pkg::OP_LOOKUP:
            begin
                hit_next = m0 || m1;
                if (m0)
                begin
                    read_value_next = val0;
                end
                else if (m1)
                begin
                    read_value_next = val1;
                end
            end
            tpr_pkg::OP_INSERT:
            begin
                s1_write = 1'b1;
                if (m0 || m1)
                begin
                    hit_next = 1'b1;
                    wr_way   = m1;
                end
                else if (!v0)
                begin
                    wr_way = 1'b0;
                end
                else if (!v1)
                begin
                    wr_way = 1'b1;
                end
                else
                begin
                    // both ways full: toggle round-robin, replace the way it names
                    s1_flip = 1'b1;
                    wr_way  = !rb_reg[s1_set_reg];
                end
            end
            tpr_pkg::OP_CLEAR:
            begin
                s1_clear = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign wr_en[0] = advance && s1_write && !wr_way;
    assign wr_en[1] = advance && s1_write && wr_way;

    always_comb
    begin
        valid_next = valid_reg;
        rb_next    = rb_reg;
        if (advance)
        begin
            if (s1_clear)
            begin
                valid_next = '0;
                rb_next    = '0;
            end
            else if (s1_write)
            begin
                valid_next[{s1_set_reg, wr_way}] = 1'b1;
                if (s1_flip)
                begin
                    rb_next[s1_set_reg] = wr_way;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            bp_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rb_reg        <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rb_reg    <= rb_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                bp_valid_reg <= advance && s1_write;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= opcode;
            s1_set_reg   <= req_set;
            s1_key_reg   <= {dst_y, dst_x, src_y, src_x};
            s1_value_reg <= value;
            bp_way_reg   <= wr_way;
            bp_set_reg   <= s1_set_reg;
            bp_entry_reg <= wr_entry;
        end
        if (advance)
        begin
            hit_reg        <= hit_next;
            read_value_reg <= read_value_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule
